>>> hw/rtl/grid_astar_path_planner_top_defines.svh
// Assertion macros for the grid A* planner.
`ifndef GRID_ASTAR_PATH_PLANNER_TOP_DEFINES_SVH
`define GRID_ASTAR_PATH_PLANNER_TOP_DEFINES_SVH
`ifndef SYNTH
`define GAPP_ASSERT(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define GAPP_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define GAPP_ASSERT(name, expr)
`define GAPP_ASSERT_NEXT(name, cond, expr)
`endif
`endif

>>> hw/rtl/gapp_pkg.sv
package gapp_pkg;

  localparam int MAX_ROWS           = 8;
  localparam int MAX_COLS           = 8;
  localparam int NCELLS             = MAX_ROWS * MAX_COLS;
  localparam int CELL_W             = 6;
  localparam int COST_W             = 16;
  localparam int COST_FRAC_BITS     = 8;
  localparam int FRONTIER_DEPTH_DEF = 1024;

  localparam logic signed [7:0] BLOCK_VALUE = 8'sd100;

  localparam logic [1:0] ST_PATH     = 2'd0;
  localparam logic [1:0] ST_NOPATH   = 2'd1;
  localparam logic [1:0] ST_BADARG   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PLAN = 1'b1;

  localparam logic signed [1:0] STEP_DR [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                                2'sd1, -2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] STEP_DC [8] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                                2'sd1, -2'sd1, 2'sd1, -2'sd1};

  typedef logic [COST_W-1:0] dist_tab_t [64];

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bv;
    longint unsigned rem;
    res = 0;
    rem = v;
    bv  = 64'd1 << 62;
    while (bv > rem) bv = bv >> 2;
    while (bv != 0) begin
      if (rem >= res + bv) begin
        rem = rem - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Euclidean distance by |dr|,|dc| in fixed point, saturated
  function automatic dist_tab_t build_dist();
    dist_tab_t        t;
    longint unsigned  d;
    for (int a = 0; a < 8; a++) begin
      for (int b = 0; b < 8; b++) begin
        d = isqrt(longint'(a * a + b * b) << (2 * COST_FRAC_BITS));
        t[a * 8 + b] = (d > 64'hFFFF) ? '1 : COST_W'(d);
      end
    end
    return t;
  endfunction

  localparam dist_tab_t DIST_TAB = build_dist();

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_INIT, CMD_SCAN_START, CMD_SCAN, CMD_POP_RD, CMD_POP_WR,
    CMD_CUR_RD, CMD_CUR_LATCH, CMD_NB_ISSUE, CMD_NB_EVAL, CMD_TRACE_START,
    CMD_TR_RD, CMD_TR_CHK, CMD_EMIT_RD, CMD_EMIT_OUT
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t    op;
    logic       emit_status;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic plan_ok;
    logic count_zero;
    logic scan_done;
    logic is_goal;
    logic nb_inb;
    logic nb_last;
    logic overflow;
    logic goal_reached;
    logic trace_end;
    logic emit_last;
  } stat_t;

endpackage

>>> hw/rtl/grid_astar_path_planner_top.sv
// Grid A* planner on an 8x8 occupancy map, 8-connected, Q8.8 Euclidean costs.
// A transaction is taken when start is high and busy is low. A load transaction
// (op 0) writes one map cell and gives no result. A plan transaction (op 1)
// holds busy high until the cycle in which its last result shows; a plan with
// bad arguments gives its status result without raising busy. Each pop scans
// the filled frontier entries, one entry a cycle, refills the popped slot from
// the last entry, reads the cell's cost in CUR_RD and latches it in CUR_LATCH,
// then passes each neighbor off the grid through NB_ISSUE and each neighbor on
// it through NB_ISSUE and NB_EVAL; the path is traced back one parent at a time
// and then sent one cell at a time. Results show on the result ports for exactly
// one cycle with result_valid high; the receiver cannot stall, so it must take
// every result as it comes. Configuration writes are taken while busy is low.
module grid_astar_path_planner_top
  import gapp_pkg::*;
#(
  parameter int FRONTIER_DEPTH = FRONTIER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [2:0]        cell_row,
  input  logic [2:0]        cell_col,
  input  logic signed [7:0] cell_value,
  input  logic [2:0]        start_row,
  input  logic [2:0]        start_col,
  input  logic [2:0]        goal_row,
  input  logic [2:0]        goal_col,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data,
  output logic              result_valid,
  output logic [1:0]        status,
  output logic [2:0]        path_row,
  output logic [2:0]        path_col,
  output logic              last
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !busy;

  gapp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  gapp_datapath #(.FRONTIER_DEPTH(FRONTIER_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cell_row(cell_row), .cell_col(cell_col), .cell_value(cell_value),
    .start_row(start_row), .start_col(start_col),
    .goal_row(goal_row), .goal_col(goal_col),
    .result_valid(result_valid), .status(status),
    .path_row(path_row), .path_col(path_col), .last(last)
  );

endmodule

>>> hw/rtl/gapp_ram.sv
module gapp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/gapp_ctrl.sv
module gapp_ctrl
  import gapp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  op,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [14:0] {
    S_IDLE       = 15'b000000000000001,
    S_LOOP       = 15'b000000000000010,
    S_SCAN       = 15'b000000000000100,
    S_POP_RD     = 15'b000000000001000,
    S_POP_WR     = 15'b000000000010000,
    S_CUR_RD     = 15'b000000000100000,
    S_CUR_LATCH  = 15'b000000001000000,
    S_NB_ISSUE   = 15'b000000010000000,
    S_NB_EVAL    = 15'b000000100000000,
    S_SEARCH_END = 15'b000001000000000,
    S_TR_RD      = 15'b000010000000000,
    S_TR_CHK     = 15'b000100000000000,
    S_EMIT_RD    = 15'b001000000000000,
    S_EMIT_OUT   = 15'b010000000000000,
    S_SPARE      = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd.op          = CMD_NONE;
    cmd.emit_status = 1'b0;
    cmd.code        = ST_PATH;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_LOAD) begin
            cmd.op = CMD_LOAD;
          end else if (stat.plan_ok) begin
            cmd.op     = CMD_INIT;
            state_next = S_LOOP;
          end else begin
            cmd.emit_status = 1'b1;
            cmd.code        = ST_BADARG;
          end
        end
      end
      S_LOOP: begin
        if (stat.count_zero) begin
          state_next = S_SEARCH_END;
        end else begin
          cmd.op     = CMD_SCAN_START;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = CMD_SCAN;
        if (stat.scan_done) state_next = S_POP_RD;
      end
      S_POP_RD: begin
        cmd.op     = CMD_POP_RD;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.op     = CMD_POP_WR;
        state_next = S_CUR_RD;
      end
      S_CUR_RD: begin
        if (stat.is_goal) begin
          state_next = S_SEARCH_END;
        end else begin
          cmd.op     = CMD_CUR_RD;
          state_next = S_CUR_LATCH;
        end
      end
      S_CUR_LATCH: begin
        cmd.op     = CMD_CUR_LATCH;
        state_next = S_NB_ISSUE;
      end
      S_NB_ISSUE: begin
        cmd.op = CMD_NB_ISSUE;
        if (stat.nb_inb) begin
          state_next = S_NB_EVAL;
        end else if (stat.nb_last) begin
          state_next = S_LOOP;
        end
      end
      S_NB_EVAL: begin
        cmd.op = CMD_NB_EVAL;
        if (stat.overflow) begin
          cmd.emit_status = 1'b1;
          cmd.code        = ST_OVERFLOW;
          state_next      = S_IDLE;
        end else if (stat.nb_last) begin
          state_next = S_LOOP;
        end else begin
          state_next = S_NB_ISSUE;
        end
      end
      S_SEARCH_END: begin
        if (stat.goal_reached) begin
          cmd.op     = CMD_TRACE_START;
          state_next = S_TR_RD;
        end else begin
          cmd.emit_status = 1'b1;
          cmd.code        = ST_NOPATH;
          state_next      = S_IDLE;
        end
      end
      S_TR_RD: begin
        cmd.op     = CMD_TR_RD;
        state_next = S_TR_CHK;
      end
      S_TR_CHK: begin
        cmd.op     = CMD_TR_CHK;
        state_next = stat.trace_end ? S_EMIT_RD : S_TR_RD;
      end
      S_EMIT_RD: begin
        cmd.op     = CMD_EMIT_RD;
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.op     = CMD_EMIT_OUT;
        state_next = stat.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/gapp_datapath.sv
`include "grid_astar_path_planner_top_defines.svh"

module gapp_datapath
  import gapp_pkg::*;
#(
  parameter int FRONTIER_DEPTH = FRONTIER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic [2:0]        cell_row,
  input  logic [2:0]        cell_col,
  input  logic signed [7:0] cell_value,
  input  logic [2:0]        start_row,
  input  logic [2:0]        start_col,
  input  logic [2:0]        goal_row,
  input  logic [2:0]        goal_col,
  output logic              result_valid,
  output logic [1:0]        status,
  output logic [2:0]        path_row,
  output logic [2:0]        path_col,
  output logic              last
);

  localparam int IDX_W = $clog2(FRONTIER_DEPTH);
  localparam int CNT_W = $clog2(FRONTIER_DEPTH + 1);
  localparam int FE_W  = COST_W + CELL_W;
  localparam logic [COST_W-1:0] STEP_STRAIGHT = DIST_TAB[8];
  localparam logic [COST_W-1:0] STEP_DIAG     = DIST_TAB[9];

  logic [3:0]        rows, cols;
  logic              map_loaded;
  logic [CELL_W-1:0] goal_cell;
  logic [NCELLS-1:0] reached;
  logic [NCELLS-1:0] bvalid;
  logic [CNT_W-1:0]  count, scan_i;
  logic              pend, best_valid;
  logic [FE_W-1:0]   best;
  logic [IDX_W-1:0]  best_idx;
  logic [CELL_W-1:0] cur, nc, tr_cur;
  logic [COST_W-1:0] cur_cost;
  logic [2:0]        nb;
  logic [6:0]        tr_n, k;

  logic              b_we, b_wdata, b_rdata;
  logic [CELL_W-1:0] b_waddr, b_raddr;
  logic              c_we;
  logic [CELL_W-1:0] c_waddr, c_raddr;
  logic [COST_W-1:0] c_wdata, c_rdata;
  logic              p_we;
  logic [CELL_W-1:0] p_waddr, p_raddr, p_wdata, p_rdata;
  logic              s_we;
  logic [CELL_W-1:0] s_waddr, s_raddr, s_wdata, s_rdata;
  logic              f_we;
  logic [IDX_W-1:0]  f_waddr, f_raddr;
  logic [FE_W-1:0]   f_wdata, f_rdata;

  logic [CELL_W-1:0]  start_cell;
  logic signed [4:0]  nx, ny;
  logic               inb, full, blk, upd, b_ok;
  logic [CELL_W-1:0]  nc_comb;
  logic [2:0]         dh_r, dh_c;
  logic [COST_W:0]    sum_nd, sum_pr;
  logic [COST_W-1:0]  nd, prio, h;

  assign start_cell = {start_row, start_col};
  assign nx = $signed({2'b00, cur[5:3]}) + 5'(STEP_DR[nb]);
  assign ny = $signed({2'b00, cur[2:0]}) + 5'(STEP_DC[nb]);
  assign inb = (nx >= 0) && (nx < $signed({1'b0, rows})) &&
               (ny >= 0) && (ny < $signed({1'b0, cols}));
  assign nc_comb = {nx[2:0], ny[2:0]};
  assign dh_r = (goal_cell[5:3] >= nc[5:3]) ? goal_cell[5:3] - nc[5:3]
                                            : nc[5:3] - goal_cell[5:3];
  assign dh_c = (goal_cell[2:0] >= nc[2:0]) ? goal_cell[2:0] - nc[2:0]
                                            : nc[2:0] - goal_cell[2:0];
  assign h      = DIST_TAB[{dh_r, dh_c}];
  assign sum_nd = {1'b0, cur_cost} + {1'b0, (nb[2] ? STEP_DIAG : STEP_STRAIGHT)};
  assign nd     = sum_nd[COST_W] ? '1 : sum_nd[COST_W-1:0];
  assign sum_pr = {1'b0, nd} + {1'b0, h};
  assign prio   = sum_pr[COST_W] ? '1 : sum_pr[COST_W-1:0];
  assign full   = (count == CNT_W'(FRONTIER_DEPTH));
  assign b_ok   = bvalid[nc] & b_rdata;
  assign blk    = b_ok;
  assign upd    = !blk && (!reached[nc] || nd < c_rdata);

  assign stat.plan_ok = map_loaded && rows != 4'd0 && rows <= 4'(MAX_ROWS) &&
                        cols != 4'd0 && cols <= 4'(MAX_COLS) &&
                        {1'b0, start_row} < rows && {1'b0, start_col} < cols &&
                        {1'b0, goal_row} < rows && {1'b0, goal_col} < cols;
  assign stat.count_zero   = (count == '0);
  assign stat.scan_done    = !pend && (scan_i == count);
  assign stat.is_goal      = (cur == goal_cell);
  assign stat.nb_inb       = inb;
  assign stat.nb_last      = (nb == 3'd7);
  assign stat.overflow     = upd && full;
  assign stat.goal_reached = reached[goal_cell];
  assign stat.trace_end    = (p_rdata == tr_cur) || (tr_n == 7'(NCELLS));
  assign stat.emit_last    = (k == tr_n - 7'd1);

  always_comb begin
    b_we    = 1'b0;
    b_waddr = {cell_row, cell_col};
    b_wdata = (cell_value == BLOCK_VALUE);
    b_raddr = nc_comb;
    c_we    = 1'b0;
    c_waddr = nc;
    c_wdata = nd;
    c_raddr = nc_comb;
    p_we    = 1'b0;
    p_waddr = nc;
    p_wdata = cur;
    p_raddr = tr_cur;
    s_we    = 1'b0;
    s_waddr = tr_n[CELL_W-1:0];
    s_wdata = tr_cur;
    s_raddr = CELL_W'(tr_n - 7'd1 - k);
    f_we    = 1'b0;
    f_waddr = count[IDX_W-1:0];
    f_wdata = {prio, nc};
    f_raddr = scan_i[IDX_W-1:0];
    unique case (cmd.op)
      CMD_LOAD: begin
        b_we = 1'b1;
      end
      CMD_INIT: begin
        c_we    = 1'b1;
        c_waddr = start_cell;
        c_wdata = '0;
        p_we    = 1'b1;
        p_waddr = start_cell;
        p_wdata = start_cell;
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = {{COST_W{1'b0}}, start_cell};
      end
      CMD_POP_RD: begin
        f_raddr = IDX_W'(count - CNT_W'(1));
      end
      CMD_POP_WR: begin
        f_we    = 1'b1;
        f_waddr = best_idx;
        f_wdata = f_rdata;
      end
      CMD_CUR_RD: begin
        c_raddr = cur;
      end
      CMD_NB_EVAL: begin
        c_we = upd;
        p_we = upd;
        f_we = upd && !full;
      end
      CMD_TR_RD: begin
        s_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows         <= 4'(MAX_ROWS);
      cols         <= 4'(MAX_COLS);
      map_loaded   <= 1'b0;
      bvalid       <= '0;
      reached      <= '0;
      count        <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) rows <= cfg_data;
        else                       cols <= cfg_data;
      end
      result_valid <= 1'b0;
      unique case (cmd.op)
        CMD_LOAD: begin
          bvalid[{cell_row, cell_col}] <= 1'b1;
          map_loaded <= 1'b1;
        end
        CMD_INIT: begin
          goal_cell <= {goal_row, goal_col};
          reached   <= NCELLS'(1) << start_cell;
          count     <= CNT_W'(1);
        end
        CMD_SCAN_START: begin
          scan_i     <= '0;
          pend       <= 1'b0;
          best_valid <= 1'b0;
        end
        CMD_SCAN: begin
          pend <= (scan_i < count);
          if (scan_i < count) scan_i <= scan_i + CNT_W'(1);
          if (pend && (!best_valid || f_rdata < best)) begin
            best       <= f_rdata;
            best_idx   <= IDX_W'(scan_i - CNT_W'(1));
            best_valid <= 1'b1;
          end
        end
        CMD_POP_WR: begin
          count <= count - CNT_W'(1);
          cur   <= best[CELL_W-1:0];
        end
        CMD_CUR_RD: begin
          nb <= 3'd0;
        end
        CMD_CUR_LATCH: begin
          cur_cost <= c_rdata;
        end
        CMD_NB_ISSUE: begin
          nc <= nc_comb;
          if (!inb) nb <= nb + 3'd1;
        end
        CMD_NB_EVAL: begin
          nb <= nb + 3'd1;
          if (upd) begin
            reached[nc] <= 1'b1;
            if (!full) count <= count + CNT_W'(1);
          end
        end
        CMD_TRACE_START: begin
          tr_n   <= '0;
          tr_cur <= goal_cell;
          k      <= '0;
        end
        CMD_TR_RD: begin
          tr_n <= tr_n + 7'd1;
        end
        CMD_TR_CHK: begin
          tr_cur <= p_rdata;
        end
        CMD_EMIT_OUT: begin
          result_valid <= 1'b1;
          status       <= ST_PATH;
          path_row     <= s_rdata[5:3];
          path_col     <= s_rdata[2:0];
          last         <= stat.emit_last;
          k            <= k + 7'd1;
        end
        default: begin
        end
      endcase
      if (cmd.emit_status) begin
        result_valid <= 1'b1;
        status       <= cmd.code;
        path_row     <= '0;
        path_col     <= '0;
        last         <= 1'b1;
      end
    end
  end

  gapp_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_blocked (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  gapp_ram #(.WIDTH(COST_W), .DEPTH(NCELLS)) u_cost (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  gapp_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  gapp_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  gapp_ram #(.WIDTH(FE_W), .DEPTH(FRONTIER_DEPTH)) u_frontier (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  `GAPP_ASSERT(a_count_bound, count <= CNT_W'(FRONTIER_DEPTH))
  `GAPP_ASSERT(a_status_last, !result_valid || status == ST_PATH || last)
  `GAPP_ASSERT_NEXT(a_push_count, cmd.op == CMD_NB_EVAL && upd && !full,
                    count == $past(count) + CNT_W'(1))

endmodule
